// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the alu executor rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, masked while reset is asserted
`define RVALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RVALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rvalu_pkg.sv =====
// ----------------------------------------------------------------------------
// rvalu_pkg
// shared types and constants of the rv32i alu executor
// ----------------------------------------------------------------------------
package rvalu_pkg;

    localparam int XLEN        = 32;
    localparam int NUM_REGS    = 32;
    localparam int RIDX_W      = 5;

    // decoupling queue between decode and execute
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // major opcodes and funct7 patterns
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [1:0] OPC_LEN32  = 2'b11;
    localparam logic [6:0] F7_ZERO    = 7'h00;
    localparam logic [6:0] F7_ALT     = 7'h20;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_LEN  = 2'd1;
    localparam t_status ST_NO_MATCH = 2'd2;

    typedef logic [3:0] t_alu_op;
    localparam t_alu_op ALU_ADD  = 4'd0;
    localparam t_alu_op ALU_SUB  = 4'd1;
    localparam t_alu_op ALU_SLL  = 4'd2;
    localparam t_alu_op ALU_SLT  = 4'd3;
    localparam t_alu_op ALU_SLTU = 4'd4;
    localparam t_alu_op ALU_XOR  = 4'd5;
    localparam t_alu_op ALU_SRL  = 4'd6;
    localparam t_alu_op ALU_SRA  = 4'd7;
    localparam t_alu_op ALU_OR   = 4'd8;
    localparam t_alu_op ALU_AND  = 4'd9;

    // decoded instruction as it travels from decode to execute
    typedef struct packed {
        t_status           status;
        logic [RIDX_W-1:0] rd;
        logic [RIDX_W-1:0] rs1;
        logic [RIDX_W-1:0] rs2;
        t_alu_op           op;
        logic              use_imm;
        logic [XLEN-1:0]   imm;
    } t_uop;

endpackage

// ===== src/rv32i_integer_alu_executor_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_integer_alu_executor_unit
// rv32i op / op-imm executor with its own 32 x 32 register file
// ----------------------------------------------------------------------------
// usage
//   slave channel takes one raw 32-bit instruction word per transaction
//   master channel returns one result transaction per instruction, in order
//   result tuser carries the status: executed, not a 32-bit encoding, or
//   no matching alu instruction; tdata carries rd, the written value and
//   the wrote flag
// pipeline and throughput
//   one instruction per clock while the receiver keeps tready high; a result
//   is presented once its instruction has passed the queue write, then
//   register read plus alu, then the output register
//   back-to-back dependent instructions run at full rate: the value being
//   written back is forwarded into the register read of the next one
// reset
//   i_rst_n low for one clock empties the queue and pipeline and marks every
//   register as zero; no memory sweep is needed, and instructions are taken
//   as soon as reset is released
// stall
//   when the receiver holds tready low the output register keeps its result,
//   the pipeline freezes and up to four instructions still collect in the
//   queue before the slave side drops tready
// ----------------------------------------------------------------------------
module rv32i_integer_alu_executor_unit
    import rvalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // instruction channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] instruction_word
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [4:0] dest_reg, [36:5] write_value, [37] wrote, zero pad
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    t_uop              dec_uop;
    t_uop              head_uop;
    logic              q_full;
    logic              q_vld;
    logic              q_pop;
    logic              push;
    t_status           res_status;
    logic [RIDX_W-1:0] res_rd;
    logic [XLEN-1:0]   res_value;
    logic              res_wrote;

    // front: decode straight into the queue
    rvalu_decode u_decode (
        .i_instr (i_s_tdata),
        .o_uop   (dec_uop)
    );

    // no transaction is taken while reset is held
    assign o_s_tready = i_rst_n && !q_full;
    assign push       = i_s_tvalid && o_s_tready;

    rvalu_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (dec_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_uop   (head_uop)
    );

    // back: register read, execute, writeback, result register
    rvalu_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (q_vld),
        .i_head     (head_uop),
        .o_pop      (q_pop),
        .o_out_vld  (o_m_tvalid),
        .i_out_rdy  (i_m_tready),
        .o_status   (res_status),
        .o_rd       (res_rd),
        .o_value    (res_value),
        .o_wrote    (res_wrote)
    );

    assign o_m_tdata = {2'b00, res_wrote, res_value, res_rd};
    assign o_m_tuser = res_status;

endmodule

// ===== src/rvalu_ram.sv =====
// ----------------------------------------------------------------------------
// rvalu_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rvalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/rvalu_decode.sv =====
// ----------------------------------------------------------------------------
// rvalu_decode
// front end: classifies an instruction word into a decoded alu operation
// ----------------------------------------------------------------------------
module rvalu_decode
    import rvalu_pkg::*;
(
    input  logic [XLEN-1:0] i_instr,
    output t_uop            o_uop
);

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;

    assign opc = i_instr[6:0];
    assign f3  = i_instr[14:12];
    assign f7  = i_instr[31:25];

    always_comb begin
        o_uop.status  = ST_OK;
        o_uop.rd      = i_instr[11:7];
        o_uop.rs1     = i_instr[19:15];
        o_uop.rs2     = i_instr[24:20];
        o_uop.op      = ALU_ADD;
        o_uop.use_imm = 1'b0;
        o_uop.imm     = {{(XLEN-12){i_instr[31]}}, i_instr[31:20]};

        if (opc[1:0] != OPC_LEN32) begin
            o_uop.status = ST_BAD_LEN;
            o_uop.rd     = '0;
        end else if (opc == OPC_OP) begin
            case (f3)
                F3_ADD: begin
                    if (f7 == F7_ZERO)      o_uop.op = ALU_ADD;
                    else if (f7 == F7_ALT)  o_uop.op = ALU_SUB;
                    else                    o_uop.status = ST_NO_MATCH;
                end
                F3_SR: begin
                    if (f7 == F7_ZERO)      o_uop.op = ALU_SRL;
                    else if (f7 == F7_ALT)  o_uop.op = ALU_SRA;
                    else                    o_uop.status = ST_NO_MATCH;
                end
                F3_SLL:  o_uop.op = ALU_SLL;
                F3_SLT:  o_uop.op = ALU_SLT;
                F3_SLTU: o_uop.op = ALU_SLTU;
                F3_XOR:  o_uop.op = ALU_XOR;
                F3_OR:   o_uop.op = ALU_OR;
                default: o_uop.op = ALU_AND;
            endcase
            // all but add/sub and the right shifts need funct7 zero
            if (f3 inside {F3_SLL, F3_SLT, F3_SLTU, F3_XOR, F3_OR, F3_AND} &&
                f7 != F7_ZERO) begin
                o_uop.status = ST_NO_MATCH;
            end
        end else if (opc == OPC_OP_IMM) begin
            o_uop.use_imm = 1'b1;
            case (f3)
                F3_ADD:  o_uop.op = ALU_ADD;
                F3_SLT:  o_uop.op = ALU_SLT;
                F3_SLTU: o_uop.op = ALU_SLTU;
                F3_XOR:  o_uop.op = ALU_XOR;
                F3_OR:   o_uop.op = ALU_OR;
                F3_AND:  o_uop.op = ALU_AND;
                F3_SLL: begin
                    o_uop.op = ALU_SLL;
                    if (f7 != F7_ZERO) o_uop.status = ST_NO_MATCH;
                end
                default: begin
                    if (f7 == F7_ZERO)      o_uop.op = ALU_SRL;
                    else if (f7 == F7_ALT)  o_uop.op = ALU_SRA;
                    else                    o_uop.status = ST_NO_MATCH;
                end
            endcase
        end else begin
            o_uop.status = ST_NO_MATCH;
        end
    end

endmodule

// ===== src/rvalu_fifo.sv =====
// ----------------------------------------------------------------------------
// rvalu_fifo
// short queue of decoded operations between decode and execute
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvalu_fifo
    import rvalu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_uop i_uop,
    output logic o_full,
    input  logic i_pop,
    output logic o_vld,
    output t_uop o_uop
);

    t_uop              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_uop;
        end
    end

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_uop  = r_mem[r_rptr];

    `RVALU_ASSERT(a_q_bounded, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
    `RVALU_ASSERT(a_q_no_underflow, i_pop |-> (r_count != '0), "pop from empty queue")

endmodule

// ===== src/rvalu_exec.sv =====
// ----------------------------------------------------------------------------
// rvalu_exec
// back end: register read, alu, writeback and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvalu_exec
    import rvalu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_vld,
    input  t_uop                i_head,
    output logic                o_pop,
    output logic                o_out_vld,
    input  logic                i_out_rdy,
    output t_status             o_status,
    output logic [RIDX_W-1:0]   o_rd,
    output logic [XLEN-1:0]     o_value,
    output logic                o_wrote
);

    // execute stage
    logic                r_ex_vld;
    t_uop                r_ex;
    logic                r_ovr1;
    logic                r_ovr2;
    logic [XLEN-1:0]     r_ovr_val1;
    logic [XLEN-1:0]     r_ovr_val2;
    logic [NUM_REGS-1:0] r_valid;

    // output stage
    logic                r_out_vld;
    t_status             r_out_status;
    logic [RIDX_W-1:0]   r_out_rd;
    logic [XLEN-1:0]     r_out_value;
    logic                r_out_wrote;

    logic                rd_go;
    logic                ex_go;
    logic                wr_en;
    logic [RIDX_W-1:0]   wr_addr;
    logic [XLEN-1:0]     alu_res;
    logic [XLEN-1:0]     ram_q1;
    logic [XLEN-1:0]     ram_q2;
    logic [XLEN-1:0]     opa;
    logic [XLEN-1:0]     opb;
    logic [XLEN-1:0]     rs2_val;
    logic                n_ovr1;
    logic                n_ovr2;
    logic [XLEN-1:0]     n_ovr_val1;
    logic [XLEN-1:0]     n_ovr_val2;

    assign ex_go = r_ex_vld && (!r_out_vld || i_out_rdy);
    assign rd_go = i_head_vld && (!r_ex_vld || ex_go);
    assign o_pop = rd_go;

    assign wr_en   = ex_go && (r_ex.status == ST_OK) && (r_ex.rd != '0);
    assign wr_addr = r_ex.rd;

    rvalu_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (alu_res),
        .i_re      (rd_go),
        .i_raddr_a (i_head.rs1),
        .i_raddr_b (i_head.rs2),
        .o_rdata_a (ram_q1),
        .o_rdata_b (ram_q2)
    );

    // same-cycle writeback forwarding, x0 and never-written entries read zero
    always_comb begin
        n_ovr1     = 1'b0;
        n_ovr_val1 = '0;
        if (wr_en && wr_addr == i_head.rs1) begin
            n_ovr1     = 1'b1;
            n_ovr_val1 = alu_res;
        end else if (i_head.rs1 == '0 || !r_valid[i_head.rs1]) begin
            n_ovr1     = 1'b1;
        end
        n_ovr2     = 1'b0;
        n_ovr_val2 = '0;
        if (wr_en && wr_addr == i_head.rs2) begin
            n_ovr2     = 1'b1;
            n_ovr_val2 = alu_res;
        end else if (i_head.rs2 == '0 || !r_valid[i_head.rs2]) begin
            n_ovr2     = 1'b1;
        end
    end

    assign opa     = r_ovr1 ? r_ovr_val1 : ram_q1;
    assign rs2_val = r_ovr2 ? r_ovr_val2 : ram_q2;
    assign opb     = r_ex.use_imm ? r_ex.imm : rs2_val;

    always_comb begin
        case (r_ex.op)
            ALU_ADD:  alu_res = opa + opb;
            ALU_SUB:  alu_res = opa - opb;
            ALU_SLL:  alu_res = opa << opb[4:0];
            ALU_SLT:  alu_res = {{(XLEN-1){1'b0}}, $signed(opa) < $signed(opb)};
            ALU_SLTU: alu_res = {{(XLEN-1){1'b0}}, opa < opb};
            ALU_XOR:  alu_res = opa ^ opb;
            ALU_SRL:  alu_res = opa >> opb[4:0];
            ALU_SRA:  alu_res = XLEN'($signed(opa) >>> opb[4:0]);
            ALU_OR:   alu_res = opa | opb;
            ALU_AND:  alu_res = opa & opb;
            default:  alu_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            if (rd_go)      r_ex_vld <= 1'b1;
            else if (ex_go) r_ex_vld <= 1'b0;
            if (ex_go)          r_out_vld <= 1'b1;
            else if (i_out_rdy) r_out_vld <= 1'b0;
            if (wr_en) r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_ex       <= i_head;
            r_ovr1     <= n_ovr1;
            r_ovr2     <= n_ovr2;
            r_ovr_val1 <= n_ovr_val1;
            r_ovr_val2 <= n_ovr_val2;
        end
        if (ex_go) begin
            r_out_status <= r_ex.status;
            r_out_rd     <= r_ex.rd;
            r_out_value  <= (r_ex.status == ST_OK) ? alu_res : '0;
            r_out_wrote  <= wr_en;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_status  = r_out_status;
    assign o_rd      = r_out_rd;
    assign o_value   = r_out_value;
    assign o_wrote   = r_out_wrote;

    `RVALU_ASSERT(a_wr_on_retire, wr_en |-> (ex_go && wr_addr != '0), "write outside retire")
    `RVALU_ASSERT_NEXT(a_wr_sets_valid, wr_en, r_valid[$past(wr_addr)], "valid bit not set")
    `RVALU_ASSERT_NEXT(a_retire_to_out, ex_go, r_out_vld, "retired op lost")

endmodule

// ===== bench/rv32i_alu_writeback_checker.sv =====
// ----------------------------------------------------------------------------
// rv32i_alu_writeback_checker
// watches both channels of the alu executor, predicts each writeback and
// compares it field by field with the result transactions, in order
// ----------------------------------------------------------------------------
module rv32i_alu_writeback_checker
    import rvalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] instruction_word
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // [4:0] dest_reg, [36:5] write_value, [37] wrote, zero pad
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        t_status           status;
        logic [RIDX_W-1:0] rd;
        logic [XLEN-1:0]   value;
        logic              wrote;
    } t_writeback;

    logic [XLEN-1:0] gpr [NUM_REGS];
    t_writeback      pending_writebacks [$];
    t_writeback      expected;
    t_writeback      observed;
    int              fail_count = 0;

    // decode and execute one instruction on the shadow register file
    function automatic t_writeback predict_writeback(input logic [31:0] word);
        t_writeback      wb;
        logic [6:0]      opc;
        logic [6:0]      f7;
        logic [2:0]      f3;
        logic [4:0]      rd;
        logic [4:0]      rs1;
        logic [4:0]      rs2;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] v;
        logic            ok;
        opc = word[6:0];
        rd  = word[11:7];
        f3  = word[14:12];
        rs1 = word[19:15];
        rs2 = word[24:20];
        f7  = word[31:25];
        a   = (rs1 == 5'd0) ? '0 : gpr[rs1];
        b   = '0;
        v   = '0;
        ok  = 1'b1;
        wb  = '0;
        if (opc[1:0] != OPC_LEN32) begin
            wb.status = ST_BAD_LEN;
            return wb;
        end
        if (opc == OPC_OP) begin
            b = (rs2 == 5'd0) ? '0 : gpr[rs2];
            case (f3)
                F3_ADD: begin
                    if (f7 == F7_ZERO)     v = a + b;
                    else if (f7 == F7_ALT) v = a - b;
                    else                   ok = 1'b0;
                end
                F3_SR: begin
                    if (f7 == F7_ZERO)     v = a >> b[4:0];
                    else if (f7 == F7_ALT) v = $signed(a) >>> b[4:0];
                    else                   ok = 1'b0;
                end
                default: begin
                    if (f7 != F7_ZERO) begin
                        ok = 1'b0;
                    end else begin
                        case (f3)
                            F3_SLL:  v = a << b[4:0];
                            F3_SLT:  v = {31'd0, $signed(a) < $signed(b)};
                            F3_SLTU: v = {31'd0, a < b};
                            F3_XOR:  v = a ^ b;
                            F3_OR:   v = a | b;
                            default: v = a & b;
                        endcase
                    end
                end
            endcase
        end else if (opc == OPC_OP_IMM) begin
            b = {{20{word[31]}}, word[31:20]};
            case (f3)
                F3_ADD:  v = a + b;
                F3_SLT:  v = {31'd0, $signed(a) < $signed(b)};
                F3_SLTU: v = {31'd0, a < b};
                F3_XOR:  v = a ^ b;
                F3_OR:   v = a | b;
                F3_AND:  v = a & b;
                F3_SLL: begin
                    if (f7 == F7_ZERO) v = a << rs2;
                    else               ok = 1'b0;
                end
                default: begin
                    if (f7 == F7_ZERO)     v = a >> rs2;
                    else if (f7 == F7_ALT) v = $signed(a) >>> rs2;
                    else                   ok = 1'b0;
                end
            endcase
        end else begin
            ok = 1'b0;
        end
        wb.rd = rd;
        if (!ok) begin
            wb.status = ST_NO_MATCH;
            return wb;
        end
        if (rd != 5'd0) gpr[rd] = v;
        wb.status = ST_OK;
        wb.value  = v;
        wb.wrote  = (rd != 5'd0);
        return wb;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) gpr[k] = '0;
            pending_writebacks.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                pending_writebacks.push_back(predict_writeback(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                observed.status = i_m_tuser;
                observed.rd     = i_m_tdata[4:0];
                observed.value  = i_m_tdata[36:5];
                observed.wrote  = i_m_tdata[37];
                if (pending_writebacks.size() == 0) begin
                    $error("result transaction with no instruction waiting for it");
                    fail_count++;
                end else begin
                    expected = pending_writebacks.pop_front();
                    if (observed.status !== expected.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               expected.status, observed.status);
                        fail_count++;
                    end
                    if (observed.rd !== expected.rd) begin
                        $error("dest_reg mismatch: expected %0d, actual %0d",
                               expected.rd, observed.rd);
                        fail_count++;
                    end
                    if (observed.value !== expected.value) begin
                        $error("write_value mismatch: expected %h, actual %h",
                               expected.value, observed.value);
                        fail_count++;
                    end
                    if (observed.wrote !== expected.wrote) begin
                        $error("wrote mismatch: expected %0d, actual %0d",
                               expected.wrote, observed.wrote);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= pending_writebacks.size();
    end

endmodule

// ===== bench/tb_rv32i_integer_alu_executor_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rv32i_integer_alu_executor_unit
// drives instruction words into the alu executor under random idling on
// both channels; a checker beside the block predicts every writeback
// ----------------------------------------------------------------------------
module tb_rv32i_integer_alu_executor_unit;
    import rvalu_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          outstanding;

    // receiver idling state
    int          stall_left   = 0;
    int          ready_cycles = 0;

    always #5 clk = ~clk;

    rv32i_integer_alu_executor_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    rv32i_alu_writeback_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // r-type and i-type encoders for the directed part
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd);
        return {imm, rs1, f3, rd, OPC_OP_IMM};
    endfunction

    // one instruction transaction, preceded by a random gap unless quiet
    task automatic send_word(input logic [31:0] word, input bit quiet);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)  gap = 0;
        else if (r < 90)      gap = $urandom_range(1, 3);
        else                  gap = $urandom_range(4, 25);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
    endtask

    // receiver: mostly ready, short stalls, the odd long one, and quiet
    // stretches where tready stays high so the pipeline runs at full rate
    always @(posedge clk) begin
        ready_cycles <= ready_cycles + 1;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if ((ready_cycles / 300) % 4 == 1 || $urandom_range(0, 99) < 65) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3)
                                                     : $urandom_range(5, 40);
        end
    end

    // stimulus
    initial begin
        logic [31:0] word;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [11:0] imm;
        int          r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // build the extreme operands: x1 = all ones, x2 = 0x7ff, x3 = 0x80000000
        send_word(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1), 1'b0);
        send_word(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2), 1'b0);
        send_word(enc_i(12'h001, 5'd0, F3_ADD, 5'd3), 1'b0);
        send_word(enc_i({F7_ZERO, 5'd31}, 5'd3, F3_SLL, 5'd3), 1'b0);
        send_word(enc_i({F7_ALT, 5'd31}, 5'd3, F3_SR, 5'd4), 1'b0);
        send_word(enc_i({F7_ZERO, 5'd31}, 5'd3, F3_SR, 5'd5), 1'b0);
        // every register-register op, shift amounts beyond 5 bits masked
        send_word(enc_r(F7_ZERO, 5'd3, 5'd1, F3_ADD, 5'd6), 1'b0);
        send_word(enc_r(F7_ALT, 5'd1, 5'd3, F3_ADD, 5'd7), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd1, 5'd2, F3_SLL, 5'd8), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd2, 5'd3, F3_SLT, 5'd9), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd2, 5'd3, F3_SLTU, 5'd10), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd2, 5'd1, F3_XOR, 5'd11), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd2, 5'd3, F3_SR, 5'd12), 1'b0);
        send_word(enc_r(F7_ALT, 5'd5, 5'd3, F3_SR, 5'd13), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd3, 5'd2, F3_OR, 5'd14), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd2, 5'd1, F3_AND, 5'd15), 1'b0);
        // immediate ops with the sign-extension extremes
        send_word(enc_i(12'h800, 5'd3, F3_SLT, 5'd16), 1'b0);
        send_word(enc_i(12'hFFF, 5'd2, F3_SLTU, 5'd17), 1'b0);
        send_word(enc_i(12'h555, 5'd1, F3_XOR, 5'd18), 1'b0);
        send_word(enc_i(12'h800, 5'd3, F3_OR, 5'd19), 1'b0);
        send_word(enc_i(12'h7FF, 5'd1, F3_AND, 5'd20), 1'b0);
        // destination x0: executes, register file untouched; then x0 as both sources
        send_word(enc_r(F7_ZERO, 5'd1, 5'd1, F3_ADD, 5'd0), 1'b0);
        send_word(enc_r(F7_ZERO, 5'd0, 5'd0, F3_OR, 5'd21), 1'b0);
        // not a 32-bit encoding
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        // no matching alu instruction: foreign opcode and bad funct7 patterns
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(enc_r(7'h01, 5'd2, 5'd1, F3_ADD, 5'd22), 1'b0);
        send_word(enc_r(F7_ALT, 5'd2, 5'd1, F3_XOR, 5'd23), 1'b0);
        send_word(enc_i({F7_ALT, 5'd4}, 5'd1, F3_SLL, 5'd24), 1'b0);
        send_word(enc_i({7'h7F, 5'd4}, 5'd1, F3_SR, 5'd25), 1'b0);

        // random part: mostly well-formed alu ops with random operands,
        // the rest raw words, foreign opcodes and broken funct7 fields
        for (int n = 0; n < 1120; n++) begin
            r   = $urandom_range(0, 99);
            f3  = 3'($urandom_range(0, 7));
            imm = 12'($urandom_range(0, 4095));
            if (r < 45) begin
                if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1)) f7 = F7_ALT;
                else                                                     f7 = F7_ZERO;
                if ($urandom_range(0, 19) == 0) f7 = 7'($urandom_range(0, 127));
                word = {f7, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), f3,
                        5'($urandom_range(0, 31)), OPC_OP};
            end else if (r < 88) begin
                if (f3 == F3_SLL || f3 == F3_SR) begin
                    imm[11:5] = (f3 == F3_SR && $urandom_range(0, 1)) ? F7_ALT : F7_ZERO;
                    if ($urandom_range(0, 19) == 0) imm[11:5] = 7'($urandom_range(0, 127));
                end
                word = {imm, 5'($urandom_range(0, 31)), f3, 5'($urandom_range(0, 31)),
                        OPC_OP_IMM};
            end else if (r < 94) begin
                word = $urandom;
            end else begin
                word = {$urandom} & 32'hFFFF_FF83;
                word[6:2] = 5'($urandom_range(0, 31));
                word[1:0] = OPC_LEN32;
            end
            send_word(word, (n / 100) % 4 == 3);
        end
        s_tvalid <= 1'b0;

        // drain: let the checker catch up, then let the pipeline settle
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
